// ----- hdl/rjac_pkg.sv -----
// ----------------------------------------------------------------------------
// Radar Jacobian package
// Shared constants for the radar measurement Jacobian block and its channels.
// ----------------------------------------------------------------------------
package rjac_pkg;

  // Default data path width and fraction bits.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Minimum squared range register.
  localparam int                CFG_W         = 17;
  localparam logic [CFG_W-1:0]  MIN_RSQ_RESET = 17'd7;

endpackage

// ----- hdl/rjac_in_if.sv -----
// ----------------------------------------------------------------------------
// Radar Jacobian input channel
// Valid/ready channel that carries one state vector.
// ----------------------------------------------------------------------------
interface rjac_in_if #(
  parameter int DATA_WIDTH = rjac_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pos_x;
  logic signed [DATA_WIDTH-1:0] pos_y;
  logic signed [DATA_WIDTH-1:0] vel_x;
  logic signed [DATA_WIDTH-1:0] vel_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// ----- hdl/rjac_out_if.sv -----
// ----------------------------------------------------------------------------
// Radar Jacobian result channel
// Valid/ready channel that carries the distinct Jacobian entries.
// ----------------------------------------------------------------------------
interface rjac_out_if #(
  parameter int DATA_WIDTH = rjac_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] range_dx;
  logic signed [DATA_WIDTH-1:0] range_dy;
  logic signed [DATA_WIDTH-1:0] bearing_dx;
  logic signed [DATA_WIDTH-1:0] bearing_dy;
  logic signed [DATA_WIDTH-1:0] rate_dx;
  logic signed [DATA_WIDTH-1:0] rate_dy;
  logic                         divide_error;

  modport source (output valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
                  rate_dy, divide_error, input ready);
  modport sink (input valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
                rate_dy, divide_error, output ready);
endinterface

// ----- hdl/rjac_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Radar Jacobian configuration channel
// Write channel for the minimum squared range register.
// ----------------------------------------------------------------------------
interface rjac_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [rjac_pkg::CFG_W-1:0]   min_range_squared;

  modport source (output valid, min_range_squared, input ready);
  modport sink (input valid, min_range_squared, output ready);
endinterface

// ----- hdl/rjac_div.sv -----
// ----------------------------------------------------------------------------
// Radar Jacobian pipelined divider
// Restoring unsigned divider, one quotient bit per register stage, with an
// overflow flag for quotients that do not fit in Q_W bits.
// ----------------------------------------------------------------------------
module rjac_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  typedef struct packed {
    logic              ovf;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [Q_W-1:0]    quo;
    logic [Q_W-1:0]    nlo;
    logic [SIDE_W-1:0] side;
  } dstage_t;

  logic       valid_r [Q_W];
  dstage_t    st_r    [Q_W];
  dstage_t    st_in;
  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;

  // The high part of the numerator must stay below the divisor, else the
  // quotient does not fit.
  always_comb begin
    hi_ext      = CMP_W'(num[NUM_W-1:Q_W]);
    den_ext     = CMP_W'(den);
    st_in.ovf   = (hi_ext >= den_ext);
    st_in.rem   = hi_ext[DEN_W-1:0];
    st_in.den   = den;
    st_in.quo   = '0;
    st_in.nlo   = num[Q_W-1:0];
    st_in.side  = side_in;
  end

  // One shift and trial subtract per stage.
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    dstage_t      prev;
    logic         prev_v;
    logic [DEN_W:0] trial;
    logic         ge;
    dstage_t      st_nxt;

    if (k == 0) begin : g_first
      assign prev   = st_in;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev   = st_r[k-1];
      assign prev_v = valid_r[k-1];
    end

    always_comb begin
      trial      = {prev.rem, prev.nlo[Q_W-1]};
      ge         = (trial >= {1'b0, prev.den});
      st_nxt     = prev;
      st_nxt.rem = ge ? DEN_W'(trial - {1'b0, prev.den}) : trial[DEN_W-1:0];
      st_nxt.quo = {prev.quo[Q_W-2:0], ge};
      st_nxt.nlo = {prev.nlo[Q_W-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_valid = valid_r[Q_W-1];
  assign quo       = st_r[Q_W-1].quo;
  assign ovf       = st_r[Q_W-1].ovf;
  assign side_out  = st_r[Q_W-1].side;

endmodule

// ----- hdl/radar_measurement_jacobian.sv -----
// ----------------------------------------------------------------------------
// Radar measurement Jacobian
// Forms the distinct nonzero entries of the 3x4 radar Jacobian from one
// fixed-point state vector, with saturation and a small-range error flag.
//
//   Channel  Direction  Payload
//   in_ch    sink       pos_x, pos_y, vel_x, vel_y
//   out_ch   source     range_dx, range_dy, bearing_dx, bearing_dy,
//                       rate_dx, rate_dy, divide_error
//   cfg_ch   sink       min_range_squared
//
// One vector is accepted per cycle while the output is not stalled; the
// pipeline holds the square root (one root bit per stage) and the two
// divider rows (one quotient bit per stage). Reset is synchronous and clears
// only the valid bits and the threshold. A stalled output holds the whole
// pipeline while the input register still takes a vector if it is empty.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian #(
  parameter int DATA_WIDTH = rjac_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rjac_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rjac_in_if.sink    in_ch,
  rjac_out_if.source out_ch,
  rjac_cfg_if.sink   cfg_ch
);

  localparam int DW   = DATA_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int W2   = 2 * DW;
  localparam int QW   = DW + 1;
  localparam int PW   = DW + QW;
  localparam int RW   = DW + 2;
  localparam int SQ_W = W2 + 2;

  localparam logic [QW-1:0] CAP_NEG = {2'b01, {(DW-1){1'b0}}};
  localparam logic [QW-1:0] CAP_POS = {2'b00, {(DW-1){1'b1}}};
  localparam logic [QW-1:0] MT_CAP  = {1'b1, {DW{1'b0}}};

  typedef struct packed {
    logic spx, spy, svx, svy;
    logic [DW-1:0] mpx, mpy, mvx, mvy;
  } split_t;

  typedef struct packed {
    logic spx, spy, svx, svy;
    logic [DW-1:0] mpx, mpy;
    logic [W2-1:0] sqx, sqy, ma, mb;
  } mul_t;

  typedef struct packed {
    logic spx, spy, sc, too_close;
    logic [DW-1:0] mpx, mpy;
    logic [W2-1:0] rsq, mc;
  } sum_t;

  typedef struct packed {
    sum_t          side;
    logic [RW-1:0] rem;
    logic [DW-1:0] root;
    logic [W2-1:0] xs;
  } sq_t;

  typedef struct packed {
    logic spx, spy, sc, too_close;
    logic [DW-1:0] mpx, mpy;
    logic [W2-1:0] rsq;
  } side1_t;

  typedef struct packed {
    logic spx, spy, sc, too_close;
    logic [DW-1:0] o0, o1, o2, o3;
    logic [W2-1:0] rsq;
    logic [QW-1:0] mt;
    logic [DW-1:0] mpx, mpy;
  } m1_t;

  typedef struct packed {
    logic spx, spy, sc, too_close;
    logic [DW-1:0] o0, o1, o2, o3;
  } side2_t;

  typedef struct packed {
    logic spx, spy, sc, too_close;
    logic [DW-1:0] o0, o1, o2, o3;
    logic [W2-1:0] rsq;
    logic [PW-1:0] ptx, pty;
  } m2_t;

  typedef struct packed {
    logic [DW-1:0] o0, o1, o2, o3, o4, o5;
    logic          err;
  } res_t;

  // Saturate an unsigned quotient to the signed range and apply the sign.
  function automatic logic [DW-1:0] sat_q(input logic neg, input logic [QW-1:0] q,
                                          input logic over);
    logic [QW-1:0] cap;
    logic [QW-1:0] m;
    cap = neg ? CAP_NEG : CAP_POS;
    m   = (over || (q > cap)) ? cap : q;
    return neg ? ((~m[DW-1:0]) + DW'(1)) : m[DW-1:0];
  endfunction

  // Magnitude of a two's complement word.
  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? ((~v) + DW'(1)) : v;
  endfunction

  logic en;
  logic ld0;
  logic out_valid_r;
  res_t out_r;
  res_t out_nxt;

  // The pipeline moves when the output register is free or being taken.
  assign en = !out_valid_r || out_ch.ready;

  // Threshold register; the port takes a transfer every cycle.
  logic [rjac_pkg::CFG_W-1:0] min_rsq_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rsq_r <= rjac_pkg::MIN_RSQ_RESET;
    end else if (cfg_ch.valid) begin
      min_rsq_r <= cfg_ch.min_range_squared;
    end
  end

  // Input register, which also fills while the rest of the pipeline stalls.
  logic          v0_r;
  logic [DW-1:0] px0_r, py0_r, vx0_r, vy0_r;

  assign ld0         = en || !v0_r;
  assign in_ch.ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ld0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0 && in_ch.valid) begin
      px0_r <= in_ch.pos_x;
      py0_r <= in_ch.pos_y;
      vx0_r <= in_ch.vel_x;
      vy0_r <= in_ch.vel_y;
    end
  end

  // Sign and magnitude split.
  logic   v1_r;
  split_t sp1_r;
  split_t sp1_nxt;

  always_comb begin
    sp1_nxt.spx = px0_r[DW-1];
    sp1_nxt.spy = py0_r[DW-1];
    sp1_nxt.svx = vx0_r[DW-1];
    sp1_nxt.svy = vy0_r[DW-1];
    sp1_nxt.mpx = mag(px0_r);
    sp1_nxt.mpy = mag(py0_r);
    sp1_nxt.mvx = mag(vx0_r);
    sp1_nxt.mvy = mag(vy0_r);
  end

  // Squares and cross products.
  logic v2_r;
  mul_t mul_r;
  mul_t mul_nxt;

  always_comb begin
    mul_nxt.spx = sp1_r.spx;
    mul_nxt.spy = sp1_r.spy;
    mul_nxt.svx = sp1_r.svx;
    mul_nxt.svy = sp1_r.svy;
    mul_nxt.mpx = sp1_r.mpx;
    mul_nxt.mpy = sp1_r.mpy;
    mul_nxt.sqx = {{DW{1'b0}}, sp1_r.mpx} * {{DW{1'b0}}, sp1_r.mpx};
    mul_nxt.sqy = {{DW{1'b0}}, sp1_r.mpy} * {{DW{1'b0}}, sp1_r.mpy};
    mul_nxt.ma  = {{DW{1'b0}}, sp1_r.mvx} * {{DW{1'b0}}, sp1_r.mpy};
    mul_nxt.mb  = {{DW{1'b0}}, sp1_r.mvy} * {{DW{1'b0}}, sp1_r.mpx};
  end

  // Squared range, small-range check and signed cross term.
  logic v3_r;
  sum_t sum_r;
  sum_t sum_nxt;
  logic sa, sb;

  always_comb begin
    sa              = mul_r.svx ^ mul_r.spy;
    sb              = !(mul_r.svy ^ mul_r.spx);
    sum_nxt.spx     = mul_r.spx;
    sum_nxt.spy     = mul_r.spy;
    sum_nxt.mpx     = mul_r.mpx;
    sum_nxt.mpy     = mul_r.mpy;
    sum_nxt.rsq     = mul_r.sqx + mul_r.sqy;
    sum_nxt.too_close = (sum_nxt.rsq == '0) || ((sum_nxt.rsq >> FB) < W2'(min_rsq_r));
    if (sa == sb) begin
      sum_nxt.sc = sa;
      sum_nxt.mc = mul_r.ma + mul_r.mb;
    end else if (mul_r.ma >= mul_r.mb) begin
      sum_nxt.sc = sa;
      sum_nxt.mc = mul_r.ma - mul_r.mb;
    end else begin
      sum_nxt.sc = sb;
      sum_nxt.mc = mul_r.mb - mul_r.ma;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp1_r <= sp1_nxt;
      mul_r <= mul_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Integer square root, one root bit per stage.
  logic sqv_r [DW];
  sq_t  sq_r  [DW];
  sq_t  sq_in;
  sq_t  sq_last;

  always_comb begin
    sq_in.side = sum_r;
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.xs   = sum_r.rsq;
  end

  for (genvar j = 0; j < DW; j++) begin : g_sqrt
    sq_t         prev;
    logic        prev_v;
    logic [RW+1:0] shifted;
    logic [RW+1:0] trial;
    logic        ge;
    sq_t         sq_nxt;

    if (j == 0) begin : g_first
      assign prev   = sq_in;
      assign prev_v = v3_r;
    end else begin : g_rest
      assign prev   = sq_r[j-1];
      assign prev_v = sqv_r[j-1];
    end

    always_comb begin
      shifted     = {prev.rem, prev.xs[W2-1:W2-2]};
      trial       = {2'b00, prev.root, 2'b01};
      ge          = (shifted >= trial);
      sq_nxt      = prev;
      sq_nxt.rem  = ge ? RW'(shifted - trial) : shifted[RW-1:0];
      sq_nxt.root = {prev.root[DW-2:0], ge};
      sq_nxt.xs   = {prev.xs[W2-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[j] <= 1'b0;
      end else if (en) begin
        sqv_r[j] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[j] <= sq_nxt;
      end
    end
  end

  assign sq_last = sq_r[DW-1];

  // First divider row: quotients by range and by squared range.
  side1_t        side1_in;
  side1_t        side1_out;
  logic          d1_valid;
  logic [QW-1:0] mt_q, rx_q, ry_q, bx_q, by_q;
  logic          mt_o, rx_o, ry_o, bx_o, by_o;

  always_comb begin
    side1_in.spx       = sq_last.side.spx;
    side1_in.spy       = sq_last.side.spy;
    side1_in.sc        = sq_last.side.sc;
    side1_in.too_close = sq_last.side.too_close;
    side1_in.mpx       = sq_last.side.mpx;
    side1_in.mpy       = sq_last.side.mpy;
    side1_in.rsq       = sq_last.side.rsq;
  end

  rjac_div #(.NUM_W(W2), .DEN_W(DW), .Q_W(QW), .SIDE_W($bits(side1_t))) u_div_mt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sqv_r[DW-1]),
    .num(sq_last.side.mc), .den(sq_last.root), .side_in(side1_in),
    .out_valid(d1_valid), .quo(mt_q), .ovf(mt_o), .side_out(side1_out)
  );

  rjac_div #(.NUM_W(DW + FB), .DEN_W(DW), .Q_W(QW), .SIDE_W(1)) u_div_rx (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sqv_r[DW-1]),
    .num({sq_last.side.mpx, {FB{1'b0}}}), .den(sq_last.root), .side_in(1'b0),
    .out_valid(), .quo(rx_q), .ovf(rx_o), .side_out()
  );

  rjac_div #(.NUM_W(DW + FB), .DEN_W(DW), .Q_W(QW), .SIDE_W(1)) u_div_ry (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sqv_r[DW-1]),
    .num({sq_last.side.mpy, {FB{1'b0}}}), .den(sq_last.root), .side_in(1'b0),
    .out_valid(), .quo(ry_q), .ovf(ry_o), .side_out()
  );

  rjac_div #(.NUM_W(DW + 2 * FB), .DEN_W(W2), .Q_W(QW), .SIDE_W(1)) u_div_bx (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sqv_r[DW-1]),
    .num({sq_last.side.mpy, {(2 * FB){1'b0}}}), .den(sq_last.side.rsq),
    .side_in(1'b0), .out_valid(), .quo(bx_q), .ovf(bx_o), .side_out()
  );

  rjac_div #(.NUM_W(DW + 2 * FB), .DEN_W(W2), .Q_W(QW), .SIDE_W(1)) u_div_by (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sqv_r[DW-1]),
    .num({sq_last.side.mpx, {(2 * FB){1'b0}}}), .den(sq_last.side.rsq),
    .side_in(1'b0), .out_valid(), .quo(by_q), .ovf(by_o), .side_out()
  );

  // Saturate the first four entries and the cross quotient.
  logic v_m1_r;
  m1_t  m1_r;
  m1_t  m1_nxt;

  always_comb begin
    m1_nxt.spx       = side1_out.spx;
    m1_nxt.spy       = side1_out.spy;
    m1_nxt.sc        = side1_out.sc;
    m1_nxt.too_close = side1_out.too_close;
    m1_nxt.o0        = sat_q(side1_out.spx, rx_q, rx_o);
    m1_nxt.o1        = sat_q(side1_out.spy, ry_q, ry_o);
    m1_nxt.o2        = sat_q(!side1_out.spy, bx_q, bx_o);
    m1_nxt.o3        = sat_q(side1_out.spx, by_q, by_o);
    m1_nxt.rsq       = side1_out.rsq;
    m1_nxt.mt        = (mt_o || (mt_q > MT_CAP)) ? MT_CAP : mt_q;
    m1_nxt.mpx       = side1_out.mpx;
    m1_nxt.mpy       = side1_out.mpy;
  end

  // Position times cross quotient.
  logic v_m2_r;
  m2_t  m2_r;
  m2_t  m2_nxt;

  always_comb begin
    m2_nxt.spx       = m1_r.spx;
    m2_nxt.spy       = m1_r.spy;
    m2_nxt.sc        = m1_r.sc;
    m2_nxt.too_close = m1_r.too_close;
    m2_nxt.o0        = m1_r.o0;
    m2_nxt.o1        = m1_r.o1;
    m2_nxt.o2        = m1_r.o2;
    m2_nxt.o3        = m1_r.o3;
    m2_nxt.rsq       = m1_r.rsq;
    m2_nxt.ptx       = {{QW{1'b0}}, m1_r.mpx} * {{DW{1'b0}}, m1_r.mt};
    m2_nxt.pty       = {{QW{1'b0}}, m1_r.mpy} * {{DW{1'b0}}, m1_r.mt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m1_r <= 1'b0;
      v_m2_r <= 1'b0;
    end else if (en) begin
      v_m1_r <= d1_valid;
      v_m2_r <= v_m1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
    end
  end

  // Second divider row: range-rate terms over squared range.
  side2_t        side2_in;
  side2_t        side2_out;
  logic          d2_valid;
  logic [QW-1:0] r4_q, r5_q;
  logic          r4_o, r5_o;

  always_comb begin
    side2_in.spx       = m2_r.spx;
    side2_in.spy       = m2_r.spy;
    side2_in.sc        = m2_r.sc;
    side2_in.too_close = m2_r.too_close;
    side2_in.o0        = m2_r.o0;
    side2_in.o1        = m2_r.o1;
    side2_in.o2        = m2_r.o2;
    side2_in.o3        = m2_r.o3;
  end

  rjac_div #(.NUM_W(PW + FB), .DEN_W(W2), .Q_W(QW), .SIDE_W($bits(side2_t))) u_div_r4 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_m2_r),
    .num({m2_r.pty, {FB{1'b0}}}), .den(m2_r.rsq), .side_in(side2_in),
    .out_valid(d2_valid), .quo(r4_q), .ovf(r4_o), .side_out(side2_out)
  );

  rjac_div #(.NUM_W(PW + FB), .DEN_W(W2), .Q_W(QW), .SIDE_W(1)) u_div_r5 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_m2_r),
    .num({m2_r.ptx, {FB{1'b0}}}), .den(m2_r.rsq), .side_in(1'b0),
    .out_valid(), .quo(r5_q), .ovf(r5_o), .side_out()
  );

  // Output register; a vector that is too close gives zeros and the flag.
  always_comb begin
    if (side2_out.too_close) begin
      out_nxt     = '0;
      out_nxt.err = 1'b1;
    end else begin
      out_nxt.o0  = side2_out.o0;
      out_nxt.o1  = side2_out.o1;
      out_nxt.o2  = side2_out.o2;
      out_nxt.o3  = side2_out.o3;
      out_nxt.o4  = sat_q(side2_out.sc ^ side2_out.spy, r4_q, r4_o);
      out_nxt.o5  = sat_q(!(side2_out.sc ^ side2_out.spx), r5_q, r5_o);
      out_nxt.err = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.range_dx     = out_r.o0;
  assign out_ch.range_dy     = out_r.o1;
  assign out_ch.bearing_dx   = out_r.o2;
  assign out_ch.bearing_dy   = out_r.o3;
  assign out_ch.rate_dx      = out_r.o4;
  assign out_ch.rate_dy      = out_r.o5;
  assign out_ch.divide_error = out_r.err;

`ifndef SYNTHESIS
  // A flagged result carries only zero entries.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_error |->
      out_ch.range_dx == '0 && out_ch.range_dy == '0 && out_ch.bearing_dx == '0 &&
      out_ch.bearing_dy == '0 && out_ch.rate_dx == '0 && out_ch.rate_dy == '0)
    else $error("flagged result with nonzero entries");

  // The input is refused only when the input register is full and the output stalls.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v0_r && out_valid_r && !out_ch.ready)
    else $error("input refused without a stalled output");

  // The last root stage holds the floor square root of the squared range.
  a_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    sqv_r[DW-1] |->
      (SQ_W'(sq_last.root) * SQ_W'(sq_last.root) <= SQ_W'(sq_last.side.rsq)) &&
      (SQ_W'(sq_last.side.rsq) <
        (SQ_W'(sq_last.root) + SQ_W'(1)) * (SQ_W'(sq_last.root) + SQ_W'(1))))
    else $error("square root stage out of bounds");
`endif

endmodule

// ----- sim/rjac_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radar Jacobian checker
// Watches the input, result and configuration channels, computes the
// expected Jacobian entries of every accepted state vector and compares
// each result transfer with the oldest expected entry set.
// ----------------------------------------------------------------------------
module rjac_checker (
  input  logic  clk,
  input  logic  rst_n,
  rjac_in_if    in_ch,
  rjac_out_if   out_ch,
  rjac_cfg_if   cfg_ch,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic [31:0] range_dx;
    logic [31:0] range_dy;
    logic [31:0] bearing_dx;
    logic [31:0] bearing_dy;
    logic [31:0] rate_dx;
    logic [31:0] rate_dy;
    logic        divide_error;
  } jac_t;

  localparam int FB = rjac_pkg::FRAC_BITS_DEF;

  jac_t                         jac_q[$];
  logic [rjac_pkg::CFG_W-1:0]   min_rsq;

  // Truncating divide of num * 2^sh by den, clamped to cap.
  function automatic logic [127:0] div_clamp(logic [127:0] num, int sh,
                                             logic [127:0] den, logic [127:0] cap);
    logic [127:0] q;
    q = (num << sh) / den;
    return (q > cap) ? cap : q;
  endfunction

  // Signed quotient as a 32-bit pattern, saturated to the signed range.
  function automatic logic [31:0] signed_quot(logic neg, logic [127:0] mag, int sh,
                                              logic [127:0] den);
    logic [127:0] cap;
    logic [127:0] m;
    cap = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = div_clamp(mag, sh, den, cap);
    return neg ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic logic [127:0] magnitude(logic [31:0] v);
    return v[31] ? {96'd0, ~v + 32'd1} : {96'd0, v};
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic jac_t jacobian(logic [31:0] px, logic [31:0] py,
                                    logic [31:0] vx, logic [31:0] vy);
    jac_t         j;
    logic [127:0] mpx, mpy, mvx, mvy, rsq, r, ma, mb, mc;
    logic [127:0] mt;
    logic         sa, sb, sc;
    mpx = magnitude(px);
    mpy = magnitude(py);
    mvx = magnitude(vx);
    mvy = magnitude(vy);
    j = '0;
    rsq = mpx * mpx + mpy * mpy;
    if (rsq == 0 || (rsq >> FB) < {111'd0, min_rsq}) begin
      j.divide_error = 1'b1;
      return j;
    end
    r = floor_sqrt(rsq);
    j.range_dx   = signed_quot(px[31], mpx, FB, r);
    j.range_dy   = signed_quot(py[31], mpy, FB, r);
    j.bearing_dx = signed_quot(!py[31], mpy, 2 * FB, rsq);
    j.bearing_dy = signed_quot(px[31], mpx, 2 * FB, rsq);
    // Cross term vx*py - vy*px in sign and magnitude form.
    sa = vx[31] != py[31];
    ma = mvx * mpy;
    sb = !(vy[31] != px[31]);
    mb = mvy * mpx;
    if (sa == sb) begin
      sc = sa;
      mc = ma + mb;
    end else if (ma >= mb) begin
      sc = sa;
      mc = ma - mb;
    end else begin
      sc = sb;
      mc = mb - ma;
    end
    mt = div_clamp(mc, 0, r, 128'h1_0000_0000);
    j.rate_dx = signed_quot(sc != py[31], mpy * mt, FB, rsq);
    j.rate_dy = signed_quot(!(sc != px[31]), mpx * mt, FB, rsq);
    return j;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Track transfers on all three channels.
  always @(posedge clk) begin
    jac_t e;
    if (!rst_n) begin
      min_rsq <= rjac_pkg::MIN_RSQ_RESET;
      jac_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) min_rsq <= cfg_ch.min_range_squared;
      if (in_ch.valid && in_ch.ready)
        jac_q.push_back(jacobian(in_ch.pos_x, in_ch.pos_y, in_ch.vel_x, in_ch.vel_y));
      if (out_ch.valid && out_ch.ready) begin
        if (jac_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $realtime);
          fail_count++;
        end else begin
          e = jac_q.pop_front();
          if (out_ch.range_dx !== e.range_dx)
            report("range_dx", out_ch.range_dx, e.range_dx);
          if (out_ch.range_dy !== e.range_dy)
            report("range_dy", out_ch.range_dy, e.range_dy);
          if (out_ch.bearing_dx !== e.bearing_dx)
            report("bearing_dx", out_ch.bearing_dx, e.bearing_dx);
          if (out_ch.bearing_dy !== e.bearing_dy)
            report("bearing_dy", out_ch.bearing_dy, e.bearing_dy);
          if (out_ch.rate_dx !== e.rate_dx)
            report("rate_dx", out_ch.rate_dx, e.rate_dx);
          if (out_ch.rate_dy !== e.rate_dy)
            report("rate_dy", out_ch.rate_dy, e.rate_dy);
          if (out_ch.divide_error !== e.divide_error)
            report("divide_error", {31'd0, out_ch.divide_error}, {31'd0, e.divide_error});
        end
      end
    end
    pending <= jac_q.size();
  end
endmodule

// ----- sim/tb_radar_measurement_jacobian.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radar Jacobian testbench
// Drives directed and random state vectors through several threshold
// settings with bursty input and a stalling receiver; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_radar_measurement_jacobian;

  localparam int LATENCY    = 3 * rjac_pkg::DATA_WIDTH_DEF + 9;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 5;
  localparam int PER_PHASE  = 290;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   vectors_sent = 0;
  int   idle_cycles = 0;

  rjac_in_if  in_ch ();
  rjac_out_if out_ch ();
  rjac_cfg_if cfg_ch ();

  radar_measurement_jacobian u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rjac_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Random field value: full range, small, tiny or extreme magnitudes.
  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3: v = $urandom_range(0, 16) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  // Offer one vector and hold it until the transfer happens.
  task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] vx, logic [31:0] vy);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.vel_x <= vx;
    in_ch.vel_y <= vy;
    do @(posedge clk); while (!in_ch.ready);
    vectors_sent++;
    @(negedge clk);
  endtask

  task automatic pause(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Write the threshold register once the pipeline has drained.
  task automatic write_threshold(logic [rjac_pkg::CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.min_range_squared <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_burst(int count);
    int left;
    int run;
    left = count;
    while (left > 0) begin
      run = $urandom_range(1, 40);
      if (run > left) run = left;
      repeat (run) send(rand_field(), rand_field(), rand_field(), rand_field());
      left -= run;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  // Stimulus.
  initial begin
    logic [rjac_pkg::CFG_W-1:0] thresholds [PHASES];
    in_ch.valid              = 1'b0;
    in_ch.pos_x              = '0;
    in_ch.pos_y              = '0;
    in_ch.vel_x              = '0;
    in_ch.vel_y              = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.min_range_squared = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed vectors at the reset threshold.
    send(32'h0, 32'h0, 32'h0001_0000, 32'h0);             // zero range
    send(32'h0000_0100, 32'h0, 32'h0, 32'h0);             // below threshold
    send(32'h0000_0aa0, 32'h0000_0300, 32'h7fff_ffff, 32'h8000_0000); // above threshold
    send(32'h0000_0b00, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);      // unit x
    send(32'h0, 32'hffff_0000, 32'h0001_0000, 32'h0);      // negative y
    send(32'h0003_0000, 32'h0004_0000, 32'hfffe_0000, 32'h0005_0000);
    send(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
    send(32'h0000_1000, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff); // saturating terms
    send(32'h0, 32'h0000_1000, 32'h8000_0000, 32'h7fff_ffff);
    send(32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000);
    pause(2);

    thresholds[0] = 17'd0;
    thresholds[1] = 17'd65536;
    thresholds[2] = 17'd1;
    thresholds[3] = rjac_pkg::CFG_W'($urandom_range(0, 17'h1_ffff));
    thresholds[4] = rjac_pkg::MIN_RSQ_RESET;
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(thresholds[p]);
      send(32'h0, 32'h0, 32'h0, 32'h0);
      send(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send(32'h0000_ffff, 32'h0, 32'h0, 32'h0);
      random_burst(PER_PHASE);
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result receiver: stall patterns of its own, one long hold-off.
  initial begin
    int  mode;
    int  seg;
    bit  held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(30, 200);
      repeat (seg) begin
        @(negedge clk);
        if (!held && vectors_sent >= 300) begin
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (400) @(negedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end
endmodule

// ----- sim.f -----
hdl/rjac_pkg.sv
hdl/rjac_in_if.sv
hdl/rjac_out_if.sv
hdl/rjac_cfg_if.sv
hdl/rjac_div.sv
hdl/radar_measurement_jacobian.sv
sim/rjac_checker.sv
sim/tb_radar_measurement_jacobian.sv
